// ===== sv/assert_macros.svh =====
// Assertion macros used by the timer table RTL (ctt_ctrl).
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CTT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("timer table assertion failed");
`define CTT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table implication failed");
`else
`define CTT_ASSERT(name, clk, rst_n, prop)
`define CTT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ctt_pkg.sv =====
// Package for the countdown timer table: item types, codes, constants.
// No dependencies; imported by every module of the block.
`default_nettype none
package ctt_pkg;

  parameter int unsigned MAX_TIMERS = 16;
  parameter int unsigned RESULT_CAP = 16;

  localparam logic signed [15:0] CNT_MIN = 16'sh8000;
  localparam logic signed [15:0] CNT_MAX = 16'sh7fff;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_LENGTHEN = 2'd1,
    CMD_STOP     = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FIRED     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROTATE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [7:0]         handler;
    logic signed [15:0] argument;
    logic signed [15:0] count;
    logic [1:0]         tclass;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic     tail_we;
  } cell_ctl_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [7:0]         handler_id;
    logic signed [15:0] handler_arg;
    logic signed [15:0] delay;
    logic [1:0]         timer_class;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         fired_id;
    logic signed [15:0] fired_arg;
    logic               last;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/countdown_timer_table.sv =====
// Start loads its result at the accepting edge; it can be taken in the cycle
// after acceptance. Lengthen, stop and tick pass the L used timers through the
// head unit, one a cycle while the output register is free, then move to
// S_DONE, which loads the final result; all but the last firing of a tick
// appear during the pass. Next item accepted once the final result is taken.
// Reset empties the table (fill count to zero).
`default_nettype none
module countdown_timer_table import ctt_pkg::*; #(
  parameter int unsigned MaxTimers = MAX_TIMERS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned LW = $clog2(MaxTimers + 1);

  cell_ctl_t     ctl;
  logic [LW-1:0] len;
  entry_t        new_entry, tail_entry;
  entry_t        chain [MaxTimers];

  ctt_ctrl #(
    .MaxTimers (MaxTimers)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .head_i      (chain[0]),
    .ctl_o       (ctl),
    .len_o       (len),
    .new_o       (new_entry),
    .tail_o      (tail_entry)
  );

  for (genvar g = 0; g < MaxTimers; g++) begin : g_cell
    entry_t left, right;
    if (g == 0) begin : g_first
      assign left = new_entry;
    end else begin : g_mid_l
      assign left = chain[g-1];
    end
    if (g == MaxTimers - 1) begin : g_last
      assign right = tail_entry;
    end else begin : g_mid_r
      assign right = chain[g+1];
    end
    ctt_cell #(
      .MaxTimers (MaxTimers),
      .Idx       (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .len_i   (len),
      .left_i  (left),
      .right_i (right),
      .tail_i  (tail_entry),
      .q_o     (chain[g])
    );
  end

endmodule
`default_nettype wire

// ===== sv/ctt_cell.sv =====
// One slot of the timer chain: holds a timer and takes from a neighbour.
// Depends on ctt_pkg.
`default_nettype none
module ctt_cell import ctt_pkg::*; #(
  parameter int unsigned MaxTimers = MAX_TIMERS,
  parameter int unsigned Idx       = 0
) (
  input  wire logic                             clk_i,
  input  wire cell_ctl_t                        ctl_i,
  input  wire logic [$clog2(MaxTimers+1)-1:0]   len_i,
  input  wire entry_t                           left_i,
  input  wire entry_t                           right_i,
  input  wire entry_t                           tail_i,
  output entry_t                                q_o
);

  localparam int unsigned LW = $clog2(MaxTimers + 1);
  localparam logic [LW-1:0] TailPos = LW'(Idx + 1);

  entry_t slot_q, slot_d;

  // rotate: cells before the list tail move towards the head, the tail
  // cell takes the processed head entry unless it was removed
  always_comb begin
    slot_d = slot_q;
    case (ctl_i.op)
      OP_INSERT: slot_d = left_i;
      OP_ROTATE: begin
        if (len_i > TailPos) begin
          slot_d = right_i;
        end else if (len_i == TailPos && ctl_i.tail_we) begin
          slot_d = tail_i;
        end
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign q_o = slot_q;

endmodule
`default_nettype wire

// ===== sv/ctt_ctrl.sv =====
// Head unit and sequencer of the timer table: command decode, per-entry
// update at the chain head, result register. Depends on ctt_pkg.
`default_nettype none
`include "assert_macros.svh"
module ctt_ctrl import ctt_pkg::*; #(
  parameter int unsigned MaxTimers = MAX_TIMERS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire in_item_t                        in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output out_item_t                            out_item_o,
  input  wire entry_t                          head_i,
  output cell_ctl_t                            ctl_o,
  output logic [$clog2(MaxTimers+1)-1:0]       len_o,
  output entry_t                               new_o,
  output entry_t                               tail_o
);

  localparam int unsigned LW = $clog2(MaxTimers + 1);
  localparam int unsigned NW = $clog2(RESULT_CAP + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PASS = 3'b010,
    S_DONE = 3'b100
  } state_e;

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return s[16] ? CNT_MIN : CNT_MAX;
    end
    return s[15:0];
  endfunction

  state_e             state_q, state_d;
  logic [LW-1:0]      len_q, len_d;
  logic [LW-1:0]      rem_q, rem_d;
  logic [NW-1:0]      n_q, n_d;
  logic               found_q, found_d;
  logic               pend_v_q, pend_v_d;
  logic [7:0]         pend_id_q;
  logic signed [15:0] pend_arg_q;
  cmd_e               cmd_q;
  logic [7:0]         id_q;
  logic signed [15:0] delay_q;
  logic [1:0]         cls_q;
  logic               out_valid_q;
  out_item_t          out_q, out_d;
  logic               out_load;

  logic               out_free, accept, full, step;
  entry_t             tail;
  logic signed [15:0] dec;
  logic               kept, match, fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (len_q == LW'(MaxTimers));
  assign step       = (state_q == S_PASS) && (rem_q != '0) && out_free;

  // head entry update
  always_comb begin
    tail  = head_i;
    kept  = 1'b1;
    match = 1'b0;
    fire  = 1'b0;
    dec   = (head_i.count == CNT_MIN) ? CNT_MIN : head_i.count - 16'sd1;
    case (cmd_q)
      CMD_TICK: begin
        if (n_q < NW'(RESULT_CAP) && head_i.tclass == cls_q) begin
          tail.count = dec;
          if (dec <= 16'sd0) begin
            fire = 1'b1;
            kept = 1'b0;
          end
        end
      end
      CMD_LENGTHEN: begin
        if (!found_q && head_i.handler == id_q) begin
          match      = 1'b1;
          tail.count = sat_add(head_i.count, delay_q);
        end
      end
      CMD_STOP: begin
        if (!found_q && head_i.handler == id_q) begin
          match = 1'b1;
          kept  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d       = state_q;
    len_d         = len_q;
    rem_d         = rem_q;
    n_d           = n_q;
    found_d       = found_q;
    pend_v_d      = pend_v_q;
    out_load      = 1'b0;
    out_d         = '0;
    ctl_o.op      = OP_HOLD;
    ctl_o.tail_we = kept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_item_i.cmd == CMD_START) begin
            out_load   = 1'b1;
            out_d.last = 1'b1;
            if (full) begin
              out_d.status = ST_FULL;
            end else begin
              out_d.status = ST_DONE;
              ctl_o.op     = OP_INSERT;
              len_d        = len_q + 1'b1;
            end
          end else begin
            rem_d    = len_q;
            n_d      = '0;
            found_d  = 1'b0;
            pend_v_d = 1'b0;
            state_d  = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (rem_q == '0) begin
          state_d = S_DONE;
        end else if (out_free) begin
          ctl_o.op = OP_ROTATE;
          rem_d    = rem_q - 1'b1;
          found_d  = found_q || match;
          if (!kept) begin
            len_d = len_q - 1'b1;
          end
          // a firing is held back until the next one so the final one can carry last
          if (fire) begin
            n_d      = n_q + 1'b1;
            pend_v_d = 1'b1;
            if (pend_v_q) begin
              out_load        = 1'b1;
              out_d.status    = ST_FIRED;
              out_d.fired_id  = pend_id_q;
              out_d.fired_arg = pend_arg_q;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          state_d    = S_IDLE;
          if (cmd_q == CMD_TICK) begin
            if (pend_v_q) begin
              out_d.status    = ST_FIRED;
              out_d.fired_id  = pend_id_q;
              out_d.fired_arg = pend_arg_q;
            end else begin
              out_d.status = ST_DONE;
            end
          end else begin
            out_d.status = found_q ? ST_DONE : ST_NOT_FOUND;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      rem_q       <= '0;
      n_q         <= '0;
      found_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      n_q      <= n_d;
      found_q  <= found_d;
      pend_v_q <= pend_v_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_item_i.cmd;
      id_q    <= in_item_i.handler_id;
      delay_q <= in_item_i.delay;
      cls_q   <= in_item_i.timer_class;
    end
    if (step && fire) begin
      pend_id_q  <= head_i.handler;
      pend_arg_q <= head_i.argument;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign len_o       = len_q;
  assign tail_o      = tail;

  always_comb begin
    new_o.handler  = in_item_i.handler_id;
    new_o.argument = in_item_i.handler_arg;
    new_o.count    = in_item_i.delay;
    new_o.tclass   = in_item_i.timer_class;
  end

  `CTT_ASSERT(a_len_bound, clk_i, rst_ni, (len_q <= LW'(MaxTimers)))
  `CTT_ASSERT(a_fire_cap, clk_i, rst_ni, (n_q <= NW'(RESULT_CAP)))
  `CTT_ASSERT(a_pass_no_grow, clk_i, rst_ni, (state_q == S_PASS |=> len_q <= $past(len_q)))
  `CTT_ASSERT_IMP(a_zero_fields, clk_i, rst_ni, out_valid_q && out_q.status != ST_FIRED, out_q.fired_id == '0 && out_q.fired_arg == '0)

endmodule
`default_nettype wire
